// ===== design/plm_pkg.sv =====
// plm_pkg: widths, sequencer states and control structs for the
// packet loss and latency monitor. No dependencies.

package plm_pkg;

   localparam int SEQ_W    = 32;
   localparam int TIME_W   = 64;
   localparam int CNT_W    = 32;
   localparam int GSIZE_W  = 16;
   localparam int SUM_W    = 48;
   localparam int ALU_W    = 64;
   localparam int DIV_STEPS = 32;
   localparam int STEP_W   = $clog2(DIV_STEPS);
   localparam int REQ_W    = SEQ_W + 2 * TIME_W;
   localparam int RSP_W    = 3 * CNT_W;

   localparam logic [GSIZE_W-1:0] GSIZE_RESET = 16'd1024;
   localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_GAP,
      ST_LAT,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   // sequencer -> datapath
   typedef struct packed {
      logic ready;
      logic do_cmp;
      logic do_gap;
      logic do_lat;
      logic do_sum;
      logic do_div;
      logic do_out;
   } ctrl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic seq_new;   // sequence above last accepted
      logic report;    // group complete
      logic out_free;  // result register can take an item
   } sts_type;

endpackage

// ===== design/packet_loss_latency_monitor.sv =====
// packet_loss_latency_monitor: top level, datapath registers and result register.
// Depends on plm_pkg, plm_alu and plm_ctrl.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  req_    | in  | req_tvalid/req_tready | seq_number, send_time, arrival_time
//  rsp_    | out | rsp_tvalid/rsp_tready | mean_latency, lost_count, dup_count
//  csr_    | in  | csr_wr_en             | group_size
//
// Schedule: one item at a time through a single shared 64-bit adder. A duplicate is only
// compared; an ordinary sample also passes gap, latency and sum. The item closing a
// group adds 32 divide steps (one quotient bit a cycle on the adder) and a result load.
// Reset: synchronous, clears counters, group state, last sequence and group_size (1024).
// Stalls: the result sits in an output register; the next item is taken while it waits,
// and only a new report stalls in its load cycle until the old result has gone.

module packet_loss_latency_monitor import plm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,   // seq_number, send_time, arrival_time
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // mean_latency, lost_count, dup_count
   input  logic               csr_wr_en,
   input  logic [GSIZE_W-1:0] csr_wr_data  // group_size
);

   ctrl_type ctrl;
   sts_type  sts;

   // captured item
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [TIME_W-1:0] sent_ff, sent_in;
   logic [TIME_W-1:0] arr_ff, arr_in;

   // running group state
   logic [SEQ_W-1:0]   last_seq_ff, last_seq_in;
   logic [GSIZE_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   miss_ff, miss_in;
   logic [CNT_W-1:0]   rep_ff, rep_in;
   logic [GSIZE_W-1:0] gsize_ff, gsize_in;

   // scratch
   logic [SEQ_W-1:0]   gap_ff, gap_in;
   logic [CNT_W-1:0]   sample_ff, sample_in;
   logic [GSIZE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   quo_ff, quo_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // shared adder
   logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_inv, alu_cin, alu_cout;

   logic [GSIZE_W-1:0] count_next;

   plm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .ctrl       (ctrl)
   );

   plm_alu u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .inv_b (alu_inv),
      .cin   (alu_cin),
      .sum   (alu_sum),
      .cout  (alu_cout)
   );

   // Operand selection. seq + ~last carries out exactly when seq > last, and its
   // low word is then the gap (seq - last - 1).
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_inv = 1'b0;
      alu_cin = 1'b0;
      if (ctrl.do_cmp) begin
         alu_a   = {{(ALU_W-SEQ_W){1'b0}}, seq_ff};
         alu_b   = {{(ALU_W-SEQ_W){1'b0}}, last_seq_ff};
         alu_inv = 1'b1;
      end else if (ctrl.do_gap) begin
         alu_a = {{(ALU_W-CNT_W){1'b0}}, miss_ff};
         alu_b = {{(ALU_W-SEQ_W){1'b0}}, gap_ff};
      end else if (ctrl.do_lat) begin
         alu_a   = arr_ff;
         alu_b   = sent_ff;
         alu_inv = 1'b1;
         alu_cin = 1'b1;
      end else if (ctrl.do_sum) begin
         alu_a = {{(ALU_W-SUM_W){1'b0}}, sum_ff};
         alu_b = {{(ALU_W-CNT_W){1'b0}}, sample_ff};
      end else if (ctrl.do_div) begin
         // trial subtract of the shifted partial remainder
         alu_a   = {{(ALU_W-GSIZE_W-1){1'b0}}, rem_ff, quo_ff[CNT_W-1]};
         alu_b   = {{(ALU_W-GSIZE_W){1'b0}}, count_ff};
         alu_inv = 1'b1;
         alu_cin = 1'b1;
      end
   end

   assign count_next = count_ff + 1'b1;

   // a group_size of zero behaves as one: count_next is never zero here
   assign sts.seq_new  = alu_cout;
   assign sts.report   = (count_next >= gsize_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      seq_in       = seq_ff;
      sent_in      = sent_ff;
      arr_in       = arr_ff;
      last_seq_in  = last_seq_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      miss_in      = miss_ff;
      rep_in       = rep_ff;
      gsize_in     = csr_wr_en ? csr_wr_data : gsize_ff;
      gap_in       = gap_ff;
      sample_in    = sample_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (ctrl.ready && req_tvalid) begin
         seq_in  = req_tdata[SEQ_W-1:0];
         sent_in = req_tdata[SEQ_W +: TIME_W];
         arr_in  = req_tdata[SEQ_W+TIME_W +: TIME_W];
      end

      if (ctrl.do_cmp) begin
         if (alu_cout) begin
            last_seq_in = seq_ff;
            gap_in      = alu_sum[SEQ_W-1:0];
         end else if (rep_ff != CNT_MAX) begin
            rep_in = rep_ff + 1'b1;
         end
      end

      if (ctrl.do_gap)
         miss_in = alu_sum[CNT_W] ? CNT_MAX : alu_sum[CNT_W-1:0];

      // latency floored at zero, capped at 32 bits
      if (ctrl.do_lat) begin
         if (!alu_cout)
            sample_in = '0;
         else if (alu_sum[ALU_W-1:CNT_W] != '0)
            sample_in = CNT_MAX;
         else
            sample_in = alu_sum[CNT_W-1:0];
      end

      // quotient fits 32 bits, so the top 16 sum bits start below the divisor
      if (ctrl.do_sum) begin
         sum_in   = alu_sum[SUM_W-1:0];
         count_in = count_next;
         rem_in   = alu_sum[SUM_W-1:CNT_W];
         quo_in   = alu_sum[CNT_W-1:0];
      end

      if (ctrl.do_div) begin
         rem_in = alu_cout ? alu_sum[GSIZE_W-1:0] : {rem_ff[GSIZE_W-2:0], quo_ff[CNT_W-1]};
         quo_in = {quo_ff[CNT_W-2:0], alu_cout};
      end

      if (ctrl.do_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {rep_ff, miss_ff, quo_ff};
         count_in     = '0;
         sum_in       = '0;
         miss_in      = '0;
         rep_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff  <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         miss_ff      <= '0;
         rep_ff       <= '0;
         gsize_ff     <= GSIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_seq_ff  <= last_seq_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         miss_ff      <= miss_in;
         rep_ff       <= rep_in;
         gsize_ff     <= gsize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      sent_ff     <= sent_in;
      arr_ff      <= arr_in;
      gap_ff      <= gap_in;
      sample_ff   <= sample_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = ctrl.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/plm_alu.sv =====
// plm_alu: shared 64-bit adder with operand inversion and carry in.
// Depends on plm_pkg.

module plm_alu import plm_pkg::*; (
   input  logic [ALU_W-1:0] a,
   input  logic [ALU_W-1:0] b,
   input  logic             inv_b,
   input  logic             cin,
   output logic [ALU_W-1:0] sum,
   output logic             cout
);

   logic [ALU_W:0] full;

   assign full = {1'b0, a} + {1'b0, b ^ {ALU_W{inv_b}}} + {{ALU_W{1'b0}}, cin};
   assign sum  = full[ALU_W-1:0];
   assign cout = full[ALU_W];

endmodule

// ===== design/plm_ctrl.sv =====
// plm_ctrl: sequencer stepping the shared adder through compare, gap,
// latency, sum and the divide loop. Depends on plm_pkg.

module plm_ctrl import plm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  sts_type  sts,
   output ctrl_type ctrl
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_CMP;
         ST_CMP:  state_in = sts.seq_new ? ST_GAP : ST_IDLE;
         ST_GAP:  state_in = ST_LAT;
         ST_LAT:  state_in = ST_SUM;
         ST_SUM:  state_in = sts.report ? ST_DIV : ST_IDLE;
         ST_DIV:  if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_OUT;
         ST_OUT:  if (sts.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      step_in = (state_ff == ST_DIV) ? step_ff + 1'b1 : '0;
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: ctrl.ready  = 1'b1;
         ST_CMP:  ctrl.do_cmp = 1'b1;
         ST_GAP:  ctrl.do_gap = 1'b1;
         ST_LAT:  ctrl.do_lat = 1'b1;
         ST_SUM:  ctrl.do_sum = 1'b1;
         ST_DIV:  ctrl.do_div = 1'b1;
         ST_OUT:  ctrl.do_out = sts.out_free;
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== design/plm_checker.sv =====
// plm_checker: port-level assertions for packet_loss_latency_monitor, with bind.
// Depends on plm_pkg.

module plm_checker import plm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [RSP_W-1:0]   rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready again straight after an item");

   a_report_then_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("new result without return to idle");

endmodule

bind packet_loss_latency_monitor plm_checker u_plm_checker (.*);
